[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file rrqq_checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[hw/rtl/rrqq_pkg.sv]
// Types and constants of the round-robin quantum queue.
// No dependencies; imported by every module of the block.
package rrqq_pkg;

  typedef enum logic [2:0] {
    EV_EMPTY     = 3'd0,
    EV_RAN       = 3'd1,
    EV_TO_IO     = 3'd2,
    EV_DEMOTED   = 3'd3,
    EV_COMPLETED = 3'd4,
    EV_ENQUEUED  = 3'd5,
    EV_FULL      = 3'd6
  } ev_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DONE = 1'b1
  } st_t;

  localparam logic OP_ENQ  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 16;
  localparam logic [CFG_AW-1:0] REG_QUANTUM = 1'd0;
  localparam logic [CFG_AW-1:0] REG_LEVEL   = 1'd1;

  localparam logic [15:0] QUANTUM_RESET = 16'd4;
  localparam logic [3:0]  ACT_NONE      = 4'hF;
  localparam logic [16:0] QUANT_FRESH   = 17'h10000;

  // Input tdata layout.
  localparam int IN_TAG_LSB   = 0;
  localparam int IN_BURST_LSB = 8;
  localparam int IN_IO_LSB    = 24;
  localparam int IN_ARR_LSB   = 40;
  localparam int IN_NOW_LSB   = 72;
  localparam int IN_DW        = 104;

  // Output tdata layout; queue count sits on top at OUT_FIX_W.
  localparam int OUT_ACT_LSB   = 0;
  localparam int OUT_TAG_LSB   = 4;
  localparam int OUT_BURST_LSB = 12;
  localparam int OUT_IO_LSB    = 28;
  localparam int OUT_ARR_LSB   = 44;
  localparam int OUT_TURN_LSB  = 76;
  localparam int OUT_SUM_LSB   = 108;
  localparam int OUT_FIX_W     = 156;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] burst;
    logic [16:0] quant;  // bit 16 marks a fresh quantum
    logic [15:0] io;
    logic [31:0] arrival;
  } entry_t;

  typedef struct packed {
    logic shift;  // take the entry of the next cell up
    logic wr;     // load the write data
  } cell_ctl_t;

endpackage

[hw/rtl/round_robin_quantum_queue_unit.sv]
// Round-robin level of a feedback scheduler, queue held in a chain of cells.
// An accepted item goes into the result registers, then into the output register once it is free.
// A new item is accepted only after the last result has loaded the output register.
// Reset: clears count, sum, state and output valid; quantum 4, level 0.
// Queue slot contents are undefined after reset. Depends on rrqq_pkg, rrqq_cell.
module round_robin_quantum_queue_unit
  import rrqq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_DW = ((OUT_FIX_W + CNT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              s_tvalid,
  output logic              s_tready,
  // proc_tag, burst_left, io_left, arrival_tick, now_tick
  input  logic [IN_DW-1:0]  s_tdata,
  // op
  input  logic [0:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // active_queue, out_tag, out_burst_left, out_io_left, out_arrival,
  // turnaround, turnaround_sum, queue_count, zero fill
  output logic [OUT_DW-1:0] m_tdata,
  // event_res
  output logic [2:0]        m_tuser
);

  logic [15:0] quantum;
  logic [2:0]  level_number;
  logic [CNT_W-1:0] count, count_next;
  logic [47:0] sum, sum_next;
  st_t state, state_next;

  entry_t cell_q [QUEUE_DEPTH];
  entry_t head, head_upd, enq_entry, cell_wdata;
  logic [15:0] q_eff;
  logic [31:0] in_now;
  logic full, accept, out_free, out_load;

  ev_t ev;
  logic pop, enq_wr, head_wr;
  logic [7:0]  o_tag;
  logic [15:0] o_burst, o_io;
  logic [31:0] o_arr, o_turn;

  ev_t res_ev;
  logic [3:0]  res_act;
  logic [7:0]  res_tag;
  logic [15:0] res_burst, res_io;
  logic [31:0] res_arr, res_turn;
  logic [CNT_W-1:0] res_cnt;
  logic [48:0] sum_add;
  logic [OUT_DW-1:0] pack;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum      <= QUANTUM_RESET;
      level_number <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_QUANTUM: quantum      <= cfg_wdata;
        REG_LEVEL:   level_number <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign head      = cell_q[0];
  assign in_now    = s_tdata[IN_NOW_LSB +: 32];
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign q_eff     = head.quant[16] ? quantum : head.quant[15:0];
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    enq_entry         = '0;
    enq_entry.tag     = s_tdata[IN_TAG_LSB +: 8];
    enq_entry.burst   = s_tdata[IN_BURST_LSB +: 16];
    enq_entry.io      = s_tdata[IN_IO_LSB +: 16];
    enq_entry.arrival = s_tdata[IN_ARR_LSB +: 32];
    enq_entry.quant   = QUANT_FRESH;

    head_upd       = head;
    head_upd.burst = head.burst - 16'd1;
    head_upd.quant = {1'b0, q_eff - 16'd1};
  end

  // Decode of the offered item against the head cell.
  always_comb begin
    ev      = EV_EMPTY;
    pop     = 1'b0;
    enq_wr  = 1'b0;
    head_wr = 1'b0;
    o_tag   = '0;
    o_burst = '0;
    o_io    = '0;
    o_arr   = '0;
    o_turn  = '0;
    if (s_tuser[0] == OP_ENQ) begin
      o_tag   = enq_entry.tag;
      o_burst = enq_entry.burst;
      o_io    = enq_entry.io;
      o_arr   = enq_entry.arrival;
      if (full) begin
        ev = EV_FULL;
      end else begin
        ev     = EV_ENQUEUED;
        enq_wr = 1'b1;
      end
    end else if (count != '0) begin
      o_tag   = head.tag;
      o_burst = head.burst;
      o_io    = head.io;
      o_arr   = head.arrival;
      if (head.burst == 16'd1 && head.io != 16'd0) begin
        ev  = EV_TO_IO;
        pop = 1'b1;
      end else if (head.burst != 16'd0) begin
        if (q_eff != 16'd0) begin
          ev      = EV_RAN;
          head_wr = 1'b1;
          o_burst = head_upd.burst;
        end else begin
          ev  = EV_DEMOTED;
          pop = 1'b1;
        end
      end else begin
        ev     = EV_COMPLETED;
        pop    = 1'b1;
        o_turn = (in_now > head.arrival) ? in_now - head.arrival : 32'd0;
      end
    end
  end

  assign cell_wdata = head_wr ? head_upd : enq_entry;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nbr;
    always_comb begin
      ctl.shift = accept && pop;
      ctl.wr    = accept && ((enq_wr && count == CNT_W'(i)) || (i == 0 && head_wr));
    end
    if (i < QUEUE_DEPTH - 1) begin : g_mid
      assign nbr = cell_q[i+1];
    end else begin : g_top
      assign nbr = enq_entry;
    end
    rrqq_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .wdata (cell_wdata),
      .nbr   (nbr),
      .q     (cell_q[i])
    );
  end

  always_comb begin
    count_next = count;
    if (accept) begin
      if (enq_wr) begin
        count_next = count + CNT_W'(1);
      end else if (pop) begin
        count_next = count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_ev    <= ev;
      res_act   <= pop ? ACT_NONE : {1'b0, level_number};
      res_tag   <= o_tag;
      res_burst <= o_burst;
      res_io    <= o_io;
      res_arr   <= o_arr;
      res_turn  <= o_turn;
      res_cnt   <= count_next;
    end
  end

  // Saturating 48-bit accumulate, applied when the result loads the output register.
  assign sum_add = {1'b0, sum} + {17'd0, res_turn};
  always_comb begin
    sum_next = sum;
    if (res_ev == EV_COMPLETED) begin
      sum_next = sum_add[48] ? '1 : sum_add[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      sum      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (out_load) begin
        sum      <= sum_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    pack = '0;
    pack[OUT_ACT_LSB +: 4]    = res_act;
    pack[OUT_TAG_LSB +: 8]    = res_tag;
    pack[OUT_BURST_LSB +: 16] = res_burst;
    pack[OUT_IO_LSB +: 16]    = res_io;
    pack[OUT_ARR_LSB +: 32]   = res_arr;
    pack[OUT_TURN_LSB +: 32]  = res_turn;
    pack[OUT_SUM_LSB +: 48]   = sum_next;
    pack[OUT_FIX_W +: CNT_W]  = res_cnt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= pack;
      m_tuser <= res_ev;
    end
  end

endmodule

[hw/rtl/rrqq_cell.sv]
// One queue slot of the process chain; pops shift toward the head.
// Depends on rrqq_pkg.
module rrqq_cell
  import rrqq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    wdata,
  input  entry_t    nbr,
  output entry_t    q
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q <= nbr;
    end else if (ctl.wr) begin
      q <= wdata;
    end
  end

endmodule

[hw/rtl/rrqq_checker.sv]
// Port-level checks of round_robin_quantum_queue_unit, bound to the top level.
// Depends on rrqq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rrqq_checker
  import rrqq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_DW = ((OUT_FIX_W + CNT_W + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_DW-1:0] m_tdata,
  input logic [2:0]        m_tuser
);

  logic leaves, keeps;

  assign leaves = (m_tuser == EV_TO_IO) || (m_tuser == EV_DEMOTED) ||
                  (m_tuser == EV_COMPLETED);
  assign keeps  = (m_tuser == EV_EMPTY) || (m_tuser == EV_RAN) ||
                  (m_tuser == EV_ENQUEUED) || (m_tuser == EV_FULL);

  // One transaction in flight: no back-to-back input accepts.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // A leaving process releases the CPU; otherwise the level keeps it.
  `ASSERT_IMPL(a_act_leave, clk, rst, m_tvalid && leaves, m_tdata[OUT_ACT_LSB +: 4] == ACT_NONE)
  `ASSERT_IMPL(a_act_keep, clk, rst, m_tvalid && keeps, m_tdata[OUT_ACT_LSB + 3] == 1'b0)
  // Turnaround is reported only for completions.
  `ASSERT_IMPL(a_turn_zero, clk, rst, m_tvalid && m_tuser != EV_COMPLETED, m_tdata[OUT_TURN_LSB +: 32] == 32'd0)

endmodule

bind round_robin_quantum_queue_unit rrqq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH))
  u_rrqq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[sim/tb_round_robin_quantum_queue_unit.sv]
// Self-checking testbench for round_robin_quantum_queue_unit.
// Drives enqueue and tick transactions, predicts every event and checks the output stream.
// Depends on rrqq_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_round_robin_quantum_queue_unit;
  import rrqq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CNT_W       = 5;
  localparam int OUT_W       = ((OUT_FIX_W + CNT_W + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 300;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [7:0]  tag;
    logic [15:0] burst;
    logic [15:0] io;
    logic [31:0] arr;
    logic        fresh;
    logic [15:0] qleft;
  } proc_t;

  typedef struct {
    ev_t         ev;
    logic [3:0]  act;
    logic [7:0]  tag;
    logic [15:0] burst;
    logic [15:0] io;
    logic [31:0] arr;
    logic [31:0] turn;
    logic [47:0] sum;
    logic [4:0]  count;
  } sched_event_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_DW-1:0]  s_tdata;  // proc_tag, burst_left, io_left, arrival_tick, now_tick
  logic [0:0]        s_tuser;  // op
  logic              m_tvalid;
  logic              m_tready;
  // active_queue, out_tag, out_burst_left, out_io_left, out_arrival,
  // turnaround, turnaround_sum, queue_count
  logic [OUT_W-1:0]  m_tdata;
  logic [2:0]        m_tuser;  // event_res

  // scheduler shadow state
  proc_t        run_queue[$];
  sched_event_t pending_events[$];
  logic [47:0]  done_sum;
  logic [15:0]  cur_quantum;
  logic [2:0]   cur_level;
  logic [31:0]  tick_clock;

  int mismatches;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;

  round_robin_quantum_queue_unit #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Advance the shadow scheduler by one accepted transaction.
  function automatic void schedule_step(logic op, logic [7:0] tag, logic [15:0] burst,
                                        logic [15:0] io, logic [31:0] arr, logic [31:0] now);
    sched_event_t r;
    proc_t        p;
    logic [15:0]  q;
    logic [31:0]  turn;
    r.ev    = EV_EMPTY;
    r.act   = {1'b0, cur_level};
    r.tag   = '0;
    r.burst = '0;
    r.io    = '0;
    r.arr   = '0;
    r.turn  = '0;
    if (op == OP_ENQ) begin
      r.tag   = tag;
      r.burst = burst;
      r.io    = io;
      r.arr   = arr;
      if (run_queue.size() >= DEPTH) begin
        r.ev = EV_FULL;
      end else begin
        p.tag   = tag;
        p.burst = burst;
        p.io    = io;
        p.arr   = arr;
        p.fresh = 1'b1;
        p.qleft = '0;
        run_queue.insert(run_queue.size(), p);
        r.ev = EV_ENQUEUED;
      end
    end else if (run_queue.size() != 0) begin
      p = run_queue[0];
      q = p.fresh ? cur_quantum : p.qleft;
      r.tag   = p.tag;
      r.burst = p.burst;
      r.io    = p.io;
      r.arr   = p.arr;
      if (p.burst == 16'd1 && p.io != 16'd0) begin
        r.ev  = EV_TO_IO;
        r.act = ACT_NONE;
        run_queue.delete(0);
      end else if (p.burst != 16'd0) begin
        if (q != 16'd0) begin
          p.burst      = p.burst - 16'd1;
          p.qleft      = q - 16'd1;
          p.fresh      = 1'b0;
          run_queue[0] = p;
          r.burst      = p.burst;
          r.ev         = EV_RAN;
        end else begin
          r.ev  = EV_DEMOTED;
          r.act = ACT_NONE;
          run_queue.delete(0);
        end
      end else begin
        turn = (now > p.arr) ? now - p.arr : 32'd0;
        if (SUM_MAX - done_sum < {16'd0, turn}) done_sum = SUM_MAX;
        else done_sum = done_sum + {16'd0, turn};
        r.ev   = EV_COMPLETED;
        r.act  = ACT_NONE;
        r.turn = turn;
        run_queue.delete(0);
      end
    end
    r.sum   = done_sum;
    r.count = 5'(run_queue.size());
    pending_events.insert(pending_events.size(), r);
  endfunction

  function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, want, got);
      mismatches++;
    end
  endfunction

  // Output checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin
    sched_event_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        $error("result transaction with no prediction pending");
        mismatches++;
      end else begin
        e = pending_events[0];
        pending_events.delete(0);
        check_field("event_res",      64'(e.ev),    64'(m_tuser));
        check_field("active_queue",   64'(e.act),   64'(m_tdata[OUT_ACT_LSB +: 4]));
        check_field("out_tag",        64'(e.tag),   64'(m_tdata[OUT_TAG_LSB +: 8]));
        check_field("out_burst_left", 64'(e.burst), 64'(m_tdata[OUT_BURST_LSB +: 16]));
        check_field("out_io_left",    64'(e.io),    64'(m_tdata[OUT_IO_LSB +: 16]));
        check_field("out_arrival",    64'(e.arr),   64'(m_tdata[OUT_ARR_LSB +: 32]));
        check_field("turnaround",     64'(e.turn),  64'(m_tdata[OUT_TURN_LSB +: 32]));
        check_field("turnaround_sum", 64'(e.sum),   64'(m_tdata[OUT_SUM_LSB +: 48]));
        check_field("queue_count",    64'(e.count), 64'(m_tdata[OUT_FIX_W +: CNT_W]));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        m_tready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
      m_tready = 1'b1;
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at a falling edge with tvalid low.
  task automatic send_item(logic op, logic [7:0] tag, logic [15:0] burst, logic [15:0] io,
                           logic [31:0] arr, logic [31:0] now);
    s_tdata  = {now, arr, io, burst, tag};
    s_tuser  = op;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    schedule_step(op, tag, burst, io, arr, now);
    @(negedge clk);
    s_tvalid = 1'b0;
    if ($urandom_range(0, 99) < tx_idle_pct) repeat (gap_len()) @(negedge clk);
  endtask

  task automatic enqueue(logic [7:0] tag, logic [15:0] burst, logic [15:0] io,
                         logic [31:0] arr);
    send_item(OP_ENQ, tag, burst, io, arr, $urandom);
  endtask

  task automatic tick(logic [31:0] now);
    send_item(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom), $urandom, now);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
    cfg_addr  = idx;
    cfg_wdata = val;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    if (idx == REG_QUANTUM) cur_quantum = val;
    else cur_level = val[2:0];
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Reset values: quantum 4, level 0, every tick outcome once.
  task automatic test_directed();
    tick(32'd0);
    enqueue(8'hFF, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
    tick(32'd0);                       // arrival after now: turnaround clamps
    enqueue(8'h00, 16'd0, 16'd0, 32'd0);
    tick(32'hFFFF_FFFF);
    enqueue(8'h5A, 16'd1, 16'hFFFF, 32'd10);
    tick(32'd11);                      // last burst unit with I/O pending
    enqueue(8'hA5, 16'hFFFF, 16'd0, 32'd20);
    repeat (5) tick(32'd25);           // four runs, then quantum spent
    enqueue(8'h3C, 16'd1, 16'd0, 32'd30);
    tick(32'd40);
    tick(32'd100);
    wait_drained();
  endtask

  // Fill every slot, then offer two more.
  task automatic test_full_queue();
    while (run_queue.size() < DEPTH)
      enqueue(8'($urandom), 16'($urandom_range(0, 3)), 16'($urandom_range(0, 1)),
              tick_clock);
    repeat (2) enqueue(8'($urandom), 16'($urandom), 16'($urandom), $urandom);
    wait_drained();
  endtask

  task automatic test_random_phase(logic [15:0] quantum, logic [2:0] level, int n_items,
                                   int max_burst, int tx_pct, int rx_pct);
    int          enq_pct;
    logic [15:0] burst;
    logic [15:0] io;
    logic [31:0] arr;
    logic [31:0] now;
    wait_drained();
    write_reg(REG_QUANTUM, quantum);
    write_reg(REG_LEVEL, {13'd0, level});
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n_items) begin
      if (run_queue.size() == 0) enq_pct = 70;
      else if (run_queue.size() >= DEPTH) enq_pct = 10;
      else enq_pct = 40;
      if ($urandom_range(0, 19) == 0 && quantum <= 16'd16) burst = 16'($urandom);
      else burst = 16'($urandom_range(0, max_burst));
      case ($urandom_range(0, 3))
        0, 1:    io = 16'd0;
        2:       io = 16'd1;
        default: io = 16'($urandom);
      endcase
      if ($urandom_range(0, 15) == 0) arr = $urandom;
      else arr = tick_clock - 32'($urandom_range(0, 50));
      if ($urandom_range(0, 99) < enq_pct) begin
        enqueue(8'($urandom), burst, io, arr);
      end else begin
        tick_clock = tick_clock + 32'($urandom_range(1, 3));
        now = ($urandom_range(0, 15) == 0) ? 32'($urandom) : tick_clock;
        tick(now);
      end
    end
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering transactions.
  task automatic test_backpressure();
    int i;
    tx_idle_pct = 0;
    hold_req = 1'b1;
    for (i = 0; i < 14; i++) begin
      if (i % 3 == 2) tick(tick_clock);
      else enqueue(8'($urandom), 16'($urandom_range(0, 4)), 16'd0, tick_clock);
    end
    wait_drained();
  endtask

  initial begin
    int guard;
    bit lost;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    hold_req    = 1'b0;
    lost        = 1'b0;
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    done_sum    = '0;
    cur_quantum = QUANTUM_RESET;
    cur_level   = 3'd0;
    tick_clock  = 32'd1000;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_queue();
    test_random_phase(16'd1,     3'd7, 200, 6, 30, 30);
    test_random_phase(16'hFFFF,  3'd3, 200, 8, 0,  0);
    test_random_phase(16'd2,     3'd5, 200, 6, 50, 50);
    test_backpressure();
    test_random_phase(16'($urandom_range(1, 16)), 3'($urandom), 200, 10, 20, 60);
    test_random_phase(16'd4,     3'd0, 200, 12, 60, 20);

    guard = 0;
    while (pending_events.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_events.size() != 0) begin
      $error("%0d predicted results never arrived", pending_events.size());
      lost = 1'b1;
    end
    if (mismatches == 0 && !lost) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
